@@ rtl/core/smsel_pkg.sv @@
// ---------------------------------------------------------------------------
// smsel_pkg: shared types and constants for the streaming median selector
// Transaction structs, action codes and the per-cell operation code.
// ---------------------------------------------------------------------------
`default_nettype none

package smsel_pkg;

	localparam int VAL_W            = 32;
	localparam int CNT_W            = 11;
	localparam int DEF_CAPACITY     = 1024;
	localparam int DEF_VALUE_WIDTH  = 32;

	typedef enum logic {
		ACT_ADD    = 1'b0,
		ACT_FINISH = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_SHIFT  = 2'd2
	} cell_op_t;

	typedef struct packed {
		action_t            action;
		logic [VAL_W-1:0]   value;
		logic               value_is_null;
	} cmd_t;

	typedef struct packed {
		logic [VAL_W-1:0]   median;
		logic               empty_res;
		logic [CNT_W-1:0]   count;
		logic               overflow;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/core/streaming_median_select.sv @@
// ---------------------------------------------------------------------------
// streaming_median_select: upper median of a group of unsigned words
// Keeps the group sorted in a chain of cells as values arrive and drains
// the chain down to the middle slot when the group is finished.
// ---------------------------------------------------------------------------
//
//  channel   handshake          payload         direction
//  -------   ----------------   -------------   ---------
//  command   start / busy       cmd   (cmd_t)   in
//  result    done (strobe)      res   (res_t)   out
//
// Adds may follow back to back, one per cycle while busy is low, as every
// cell compares against the broadcast value in parallel. A finish on a
// group of n values holds busy while the chain shifts towards slot 0, one
// slot per cycle, until the value from slot n/2 reaches it; done strobes
// in the same cycle that busy falls. A finish on an empty group strobes
// done in the next cycle without raising busy. Reset clears the fill count, the drop
// flag and the sequencer; cell contents need no clearing. The receiver
// cannot stall: each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module streaming_median_select #(
	parameter int CAPACITY    = smsel_pkg::DEF_CAPACITY,
	parameter int VALUE_WIDTH = smsel_pkg::DEF_VALUE_WIDTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire smsel_pkg::cmd_t cmd,
	output logic                 done,
	output smsel_pkg::res_t      res
);

	// stored width: the value port never carries more than VAL_W bits
	localparam int DW = (VALUE_WIDTH < smsel_pkg::VAL_W) ? VALUE_WIDTH : smsel_pkg::VAL_W;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_DRAIN = 1'b1
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic                drop_q;
	logic [CW-1:0]       steps_q;
	logic                done_q;
	smsel_pkg::res_t     res_q;

	smsel_pkg::cell_op_t op;
	logic                accept;
	logic                add_ok;
	logic [DW-1:0]       din;

	logic [DW-1:0]       cell_val [CAPACITY];
	logic                cell_gt  [CAPACITY];

	assign accept = start && !busy;
	assign din    = cmd.value[DW-1:0];
	// a non-null add with room left goes into the chain
	assign add_ok = accept && (cmd.action == smsel_pkg::ACT_ADD) && !cmd.value_is_null &&
	                (count_q < CW'(CAPACITY));

	always_comb begin
		op = smsel_pkg::OP_HOLD;
		if (add_ok) begin
			op = smsel_pkg::OP_INSERT;
		end else if ((state_q == ST_DRAIN) && (steps_q != '0)) begin
			op = smsel_pkg::OP_SHIFT;
		end
	end

	// sorted chain: slot 0 holds the smallest value
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DW-1:0] left_val;
		logic          left_gt;
		logic [DW-1:0] right_val;

		if (i == 0) begin : g_first
			assign left_val = din;
			assign left_gt  = 1'b0;
		end else begin : g_mid
			assign left_val = cell_val[i-1];
			assign left_gt  = cell_gt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_val = cell_val[i];
		end else begin : g_inner
			assign right_val = cell_val[i+1];
		end

		smsel_cell #(
			.IDX (i),
			.CW  (CW),
			.DW  (DW)
		) u_cell (
			.clk       (clk),
			.op        (op),
			.din       (din),
			.count     (count_q),
			.left_val  (left_val),
			.left_gt   (left_gt),
			.right_val (right_val),
			.val       (cell_val[i]),
			.gt        (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			drop_q  <= 1'b0;
			steps_q <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (cmd.action == smsel_pkg::ACT_ADD)) begin
						// count the value, or note the drop when full
						if (add_ok) begin
							count_q <= count_q + CW'(1);
						end else if (!cmd.value_is_null) begin
							drop_q <= 1'b1;
						end
					end else if (accept) begin
						if (count_q == '0) begin
							// empty group: report at once
							done_q          <= 1'b1;
							res_q.median    <= '0;
							res_q.empty_res <= 1'b1;
							res_q.count     <= '0;
							res_q.overflow  <= drop_q;
							drop_q          <= 1'b0;
						end else begin
							// drain down to slot count/2
							steps_q <= count_q >> 1;
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (steps_q == '0) begin
						done_q          <= 1'b1;
						res_q.median    <= smsel_pkg::VAL_W'(cell_val[0]);
						res_q.empty_res <= 1'b0;
						res_q.count     <= smsel_pkg::CNT_W'(count_q);
						res_q.overflow  <= drop_q;
						count_q         <= '0;
						drop_q          <= 1'b0;
						state_q         <= ST_IDLE;
					end else begin
						steps_q <= steps_q - CW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

	// ---- assertions --------------------------------------------------------

	// a result is never shown while a drain is still running
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	// the fill count never exceeds the chain length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	// an empty flag goes with a zero count and zero median
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res.empty_res == (res.count == '0)) && (!res.empty_res || res.median == '0))
		else $error("empty flag inconsistent with count");

	// a finish on an empty group reports in the next cycle
	a_empty_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.action == smsel_pkg::ACT_FINISH && count_q == '0) |=> done)
		else $error("empty finish not reported");

	// the group is cleared once its result goes out
	a_clear_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (count_q == '0) && !drop_q)
		else $error("group not cleared after report");

endmodule

`default_nettype wire

@@ rtl/core/smsel_cell.sv @@
// ---------------------------------------------------------------------------
// smsel_cell: one slot of the sorted insertion chain
// Holds one value; inserts, shifts from its neighbours or holds.
// ---------------------------------------------------------------------------
`default_nettype none

module smsel_cell #(
	parameter int IDX = 0,
	parameter int CW  = 11,
	parameter int DW  = 32
) (
	input  wire logic                clk,
	input  wire smsel_pkg::cell_op_t op,
	input  wire logic [DW-1:0]       din,
	input  wire logic [CW-1:0]       count,
	input  wire logic [DW-1:0]       left_val,
	input  wire logic                left_gt,
	input  wire logic [DW-1:0]       right_val,
	output logic [DW-1:0]            val,
	output logic                     gt
);

	logic occ;
	logic at_end;

	// slot is occupied when it lies below the fill count
	assign occ    = (count > CW'(IDX));
	assign at_end = (count == CW'(IDX));
	assign gt     = occ && (val > din);

	always_ff @(posedge clk) begin
		unique case (op)
			smsel_pkg::OP_INSERT: begin
				// open a gap: larger values move one slot up
				if (left_gt) begin
					val <= left_val;
				end else if (gt || at_end) begin
					val <= din;
				end
			end
			smsel_pkg::OP_SHIFT: begin
				val <= right_val;
			end
			default: begin
				val <= val;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: self-checking bench for streaming_median_select
// Drives groups of add transactions closed by a finish transaction. A sorted
// shadow copy of each group gives the expected upper median, count, empty and
// overflow flags. Every done strobe is checked against the oldest expectation.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = smsel_pkg::DEF_CAPACITY;
	localparam int VW  = smsel_pkg::DEF_VALUE_WIDTH;
	localparam logic [smsel_pkg::VAL_W-1:0] VALUE_MASK =
		(VW >= smsel_pkg::VAL_W) ? {smsel_pkg::VAL_W{1'b1}} :
		smsel_pkg::VAL_W'((64'd1 << VW) - 64'd1);
	// Longest finish: a full drain of the chain, then the strobe; pad a little.
	localparam int DRAIN_CYCLES = CAP / 2 + 16;

	logic            clk    = 1'b0;
	logic            arst_n = 1'b0;
	logic            start  = 1'b0;
	smsel_pkg::cmd_t cmd    = '0;
	logic            busy;
	logic            done;
	smsel_pkg::res_t res;

	streaming_median_select #(
		.CAPACITY    (CAP),
		.VALUE_WIDTH (VW)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.res    (res)
	);

	always #4 clk = ~clk;

	// Shadow of the current group, kept in ascending order as values arrive.
	logic [smsel_pkg::VAL_W-1:0] group_sorted [CAP];
	int unsigned                 group_len     = 0;
	bit                          group_dropped = 1'b0;

	// Results owed by the block, oldest first.
	smsel_pkg::res_t             pending_medians [$];

	int unsigned                 fail_count = 0;
	int unsigned                 items_sent = 0;
	bit                          allow_idle = 1'b1;

	task automatic report_mismatch(input string what,
			input logic [smsel_pkg::VAL_W-1:0] got,
			input logic [smsel_pkg::VAL_W-1:0] want);
		$display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Insert one value into the shadow group; drop it and flag once full.
	task automatic add_to_group(input logic [smsel_pkg::VAL_W-1:0] v);
		int j;
		if (group_len < CAP) begin
			j = group_len;
			while (j > 0 && group_sorted[j-1] > v) begin
				group_sorted[j] = group_sorted[j-1];
				j--;
			end
			group_sorted[j] = v;
			group_len++;
		end else begin
			group_dropped = 1'b1;
		end
	endtask

	// Close the group: upper median at sorted index len/2, then clear.
	task automatic close_group(output smsel_pkg::res_t r);
		r.median    = (group_len > 0) ? group_sorted[group_len / 2] : '0;
		r.empty_res = (group_len == 0);
		r.count     = smsel_pkg::CNT_W'(group_len);
		r.overflow  = group_dropped;
		group_len     = 0;
		group_dropped = 1'b0;
	endtask

	// Send one transaction. Inputs move on the falling edge; the transaction is
	// taken at the first rising edge that sees busy low. Start stays high
	// between back-to-back transactions and is lowered for an idle burst or in wait_for_results.
	task automatic send_cmd(input smsel_pkg::action_t act,
			input logic [smsel_pkg::VAL_W-1:0] v, input logic nul);
		int              gap;
		smsel_pkg::res_t r;
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		cmd   <= '{action: act, value: v, value_is_null: nul};
		do @(posedge clk); while (busy);
		if (act == smsel_pkg::ACT_ADD) begin
			if (!nul)
				add_to_group(v & VALUE_MASK);
		end else begin
			close_group(r);
			pending_medians.push_back(r);
		end
		items_sent++;
	endtask

	// Hold the sender off until every owed result has come back.
	task automatic wait_for_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_medians.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [smsel_pkg::VAL_W-1:0] pick_value(input int unsigned mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 7);       // heavy duplicates
			2: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return 32'h8000_0000;
					default: return 32'h7FFF_FFFF;
				endcase
			end
			default: return $urandom | 32'hFFFF_0000; // close values near the top
		endcase
	endfunction

	// Compare each strobed result against the oldest expectation.
	always @(posedge clk) begin : result_monitor
		smsel_pkg::res_t want;
		if (arst_n && done) begin
			if (pending_medians.size() == 0) begin
				report_mismatch("unexpected result, median", res.median, '0);
			end else begin
				want = pending_medians.pop_front();
				if (res.median !== want.median)
					report_mismatch("median", res.median, want.median);
				if (res.empty_res !== want.empty_res)
					report_mismatch("empty_res", smsel_pkg::VAL_W'(res.empty_res),
						smsel_pkg::VAL_W'(want.empty_res));
				if (res.count !== want.count)
					report_mismatch("count", smsel_pkg::VAL_W'(res.count),
						smsel_pkg::VAL_W'(want.count));
				if (res.overflow !== want.overflow)
					report_mismatch("overflow", smsel_pkg::VAL_W'(res.overflow),
						smsel_pkg::VAL_W'(want.overflow));
			end
		end
	end

	// Edges of the fields, nulls, empty groups and the even-size upper median.
	task automatic test_directed();
		// Empty group; the finish fields carry junk that must be ignored.
		send_cmd(smsel_pkg::ACT_FINISH, '1, 1'b1);
		// Only nulls: still an empty group.
		send_cmd(smsel_pkg::ACT_ADD, 32'h0000_0005, 1'b1);
		send_cmd(smsel_pkg::ACT_ADD, '1, 1'b1);
		send_cmd(smsel_pkg::ACT_FINISH, '0, 1'b0);
		// Single zero.
		send_cmd(smsel_pkg::ACT_ADD, '0, 1'b0);
		send_cmd(smsel_pkg::ACT_FINISH, 32'hA5A5_A5A5, 1'b0);
		// Two values: the upper of the pair is reported.
		send_cmd(smsel_pkg::ACT_ADD, '1, 1'b0);
		send_cmd(smsel_pkg::ACT_ADD, '0, 1'b0);
		send_cmd(smsel_pkg::ACT_FINISH, 32'h5A5A_5A5A, 1'b1);
		// Odd group with a null in the middle.
		send_cmd(smsel_pkg::ACT_ADD, 32'd3, 1'b0);
		send_cmd(smsel_pkg::ACT_ADD, 32'd1, 1'b0);
		send_cmd(smsel_pkg::ACT_ADD, 32'd9, 1'b1);
		send_cmd(smsel_pkg::ACT_ADD, 32'd2, 1'b0);
		send_cmd(smsel_pkg::ACT_FINISH, '0, 1'b1);
		// Unsigned ordering across the sign bit, with duplicates.
		send_cmd(smsel_pkg::ACT_ADD, 32'h8000_0000, 1'b0);
		send_cmd(smsel_pkg::ACT_ADD, 32'h7FFF_FFFF, 1'b0);
		send_cmd(smsel_pkg::ACT_ADD, 32'd5, 1'b0);
		send_cmd(smsel_pkg::ACT_ADD, 32'd5, 1'b0);
		send_cmd(smsel_pkg::ACT_FINISH, '1, 1'b0);
	endtask

	// Fill to capacity, send a null when full, then push two values past it:
	// the full count comes back with the drop flag set.
	task automatic test_capacity();
		for (int k = 0; k < CAP; k++)
			send_cmd(smsel_pkg::ACT_ADD, $urandom, 1'b0);
		send_cmd(smsel_pkg::ACT_ADD, $urandom, 1'b1);
		send_cmd(smsel_pkg::ACT_ADD, $urandom, 1'b0);
		send_cmd(smsel_pkg::ACT_ADD, '1, 1'b0);
		send_cmd(smsel_pkg::ACT_FINISH, $urandom, 1'b1);
		// A short group right after to show the drop flag was cleared.
		send_cmd(smsel_pkg::ACT_ADD, 32'd7, 1'b0);
		send_cmd(smsel_pkg::ACT_FINISH, '0, 1'b0);
	endtask

	// Random groups, mostly small, with nulls sprinkled in and the odd long one.
	task automatic test_random_groups(input int unsigned n_items);
		int unsigned stop_at;
		int unsigned size;
		int unsigned mode;
		int unsigned groups;
		int unsigned pick;
		logic        nul;
		stop_at = items_sent + n_items;
		groups  = 0;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 75)
				size = $urandom_range(0, 9);
			else if (pick < 95)
				size = $urandom_range(10, 40);
			else
				size = $urandom_range(41, 160);
			mode = $urandom_range(0, 3);
			for (int k = 0; k < size; k++) begin
				nul = ($urandom_range(0, 7) == 0);
				send_cmd(smsel_pkg::ACT_ADD,
					nul ? smsel_pkg::VAL_W'($urandom) : pick_value(mode), nul);
			end
			send_cmd(smsel_pkg::ACT_FINISH, $urandom, 1'($urandom_range(0, 1)));
			groups++;
			// Let the pipe drain now and then so the sender restarts from idle.
			if (groups % 4 == 2)
				wait_for_results();
		end
	endtask

	// No idling: adds and finishes back to back, including finish after finish.
	task automatic test_back_to_back(input int unsigned n_items);
		int unsigned stop_at;
		int unsigned size;
		stop_at    = items_sent + n_items;
		allow_idle = 1'b0;
		while (items_sent < stop_at) begin
			size = $urandom_range(0, 5);
			for (int k = 0; k < size; k++)
				send_cmd(smsel_pkg::ACT_ADD, $urandom, 1'($urandom_range(0, 5) == 0));
			send_cmd(smsel_pkg::ACT_FINISH, $urandom, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_capacity();
		test_random_groups(100);
		test_back_to_back(60);
		wait_for_results();
		// Watch for stray strobes over the longest finish.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

@@ streaming_median_select.f @@
rtl/core/smsel_pkg.sv
rtl/core/smsel_cell.sv
rtl/core/streaming_median_select.sv
sim/testbench.sv
